// File: rtl/core/uartrb_pkg.sv
package uartrb_pkg;

    // Largest ring the memories are sized for
    localparam int MAX_DEPTH_DEF = 256;

    // Configuration port geometry
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_PORT_OPEN = 2'd0;
    localparam logic [1:0] REG_RX_SIZE   = 2'd1;
    localparam logic [1:0] REG_TX_SIZE   = 2'd2;

    // Reset values
    localparam logic [3:0] SIZE_LG_RESET = 4'd6;

    // Item modes
    localparam logic [2:0] MODE_HOST_WR = 3'd0;
    localparam logic [2:0] MODE_HOST_RD = 3'd1;
    localparam logic [2:0] MODE_LINE_RX = 3'd2;
    localparam logic [2:0] MODE_TX_RDY  = 3'd3;
    localparam logic [2:0] MODE_FLUSH   = 3'd4;

    // Stream widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    // Commands to one ring for the current cycle
    typedef struct packed {
        logic push;
        logic pop;
        logic flush;
        logic clear;
    } ring_ctrl_t;

    // Ring occupancy flags
    typedef struct packed {
        logic empty;
        logic full;
    } ring_stat_t;

    // Configuration register contents and size-write pulses
    typedef struct packed {
        logic       port_open;
        logic [3:0] rx_size_lg;
        logic [3:0] tx_size_lg;
        logic       rx_clear;
        logic       tx_clear;
    } cfg_t;

endpackage

// File: rtl/core/uart_rx_tx_ring_buffers.sv
// Host/line byte ring pair. Each item on the s_ stream is one event: host
// write, host read, line byte received, transmit ready or flush; each gives
// exactly one result item on the m_ stream. An item is taken into an input
// register, handled against the ring pointers and the two byte memories (one
// write port and one registered read port each), and its result is
// registered in the output register in the cycle after handling. One item per
// cycle is sustained while m_tready stays high; a result held by m_tready low
// holds the input register and drops s_tready. No clearing pass is needed
// after reset. Each ring keeps one slot empty, so a ring of 2^n slots holds
// 2^n-1 bytes; sizes are clamped to the memory depth. Write configuration
// only while no item is in flight; writing a size register empties that ring.
module uart_rx_tx_ring_buffers #(
    parameter int MAX_DEPTH = uartrb_pkg::MAX_DEPTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // s_tdata: mode[2:0], data_byte[10:3], zero fill [15:11]
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [uartrb_pkg::S_TDATA_W-1:0]     s_tdata,
    // m_tdata: read_data[7:0], read_valid[8], line_data[16:9], line_valid[17],
    //          accepted[18], rx_available[27:19], tx_request[28], zero [31:29]
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [uartrb_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [uartrb_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [uartrb_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [uartrb_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                 pready
);
    import uartrb_pkg::*;

    localparam int AW = $clog2(MAX_DEPTH + 1) - 1;

    cfg_t       cfg;
    ring_ctrl_t rx_ctrl, tx_ctrl;
    ring_stat_t rx_stat, tx_stat;
    logic [AW-1:0] rx_count, tx_count_unused_free;
    logic [7:0] rx_rd_data, tx_rd_data;

    logic       s1_valid_reg;
    logic [2:0] s1_mode_reg;
    logic [7:0] s1_byte_reg;
    logic       out_free, fire;

    logic       acc, rv, lv;
    logic       irq_reg, irq_next;
    logic [AW-1:0] avail_cnt;
    logic [8:0] avail;

    logic       m_valid_reg;
    logic       rv_reg, lv_reg, acc_reg;
    logic [8:0] avail_reg;
    logic [7:0] read_data, line_data;

    uartrb_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    uartrb_ring #(.MAX_DEPTH(MAX_DEPTH)) u_rx_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .size_lg (cfg.rx_size_lg),
        .ctrl    (rx_ctrl),
        .wr_data (s1_byte_reg),
        .stat    (rx_stat),
        .count   (rx_count),
        .rd_data (rx_rd_data)
    );

    uartrb_ring #(.MAX_DEPTH(MAX_DEPTH)) u_tx_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .size_lg (cfg.tx_size_lg),
        .ctrl    (tx_ctrl),
        .wr_data (s1_byte_reg),
        .stat    (tx_stat),
        .count   (tx_count_unused_free),
        .rd_data (tx_rd_data)
    );

    // Handshake: hold the input item until the result register is free
    assign out_free = !m_valid_reg || m_tready;
    assign fire     = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            s1_valid_reg <= 1'b1;
        end else if (fire) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            s1_mode_reg <= s_tdata[2:0];
            s1_byte_reg <= s_tdata[10:3];
        end
    end

    // Decode the event against the ring state
    always_comb begin
        rx_ctrl   = '0;
        tx_ctrl   = '0;
        acc       = 1'b0;
        rv        = 1'b0;
        lv        = 1'b0;
        irq_next  = irq_reg;
        avail_cnt = rx_count;
        rx_ctrl.clear = cfg.rx_clear;
        tx_ctrl.clear = cfg.tx_clear;
        if (fire) begin
            unique case (s1_mode_reg)
                MODE_HOST_WR: begin
                    if (cfg.port_open) begin
                        acc          = !tx_stat.full;
                        tx_ctrl.push = !tx_stat.full;
                        irq_next     = 1'b1;
                    end
                end
                MODE_HOST_RD: begin
                    if (cfg.port_open && !rx_stat.empty) begin
                        rv          = 1'b1;
                        rx_ctrl.pop = 1'b1;
                        avail_cnt   = rx_count - AW'(1);
                    end
                end
                MODE_LINE_RX: begin
                    if (cfg.port_open && !rx_stat.full) begin
                        acc          = 1'b1;
                        rx_ctrl.push = 1'b1;
                        avail_cnt    = rx_count + AW'(1);
                    end
                end
                MODE_TX_RDY: begin
                    if (!tx_stat.empty) begin
                        lv          = 1'b1;
                        tx_ctrl.pop = 1'b1;
                    end else begin
                        irq_next = 1'b0;
                    end
                end
                MODE_FLUSH: begin
                    rx_ctrl.flush = 1'b1;
                    tx_ctrl.flush = 1'b1;
                    avail_cnt     = '0;
                end
                default: ;
            endcase
        end
        avail = cfg.port_open ? 9'(avail_cnt) : 9'h1FF;
    end

    // Transmit request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            irq_reg <= 1'b0;
        end else begin
            irq_reg <= irq_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            rv_reg    <= rv;
            lv_reg    <= lv;
            acc_reg   <= acc;
            avail_reg <= avail;
        end
    end

    // Popped bytes come from the ring read registers; zero when nothing popped
    assign read_data = rv_reg ? rx_rd_data : 8'h00;
    assign line_data = lv_reg ? tx_rd_data : 8'h00;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, irq_reg, avail_reg, acc_reg, lv_reg, line_data,
                       rv_reg, read_data};

    // A result never both stores and pops a byte
    a_acc_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(acc_reg && (rv_reg || lv_reg)))
        else $error("result both stored and popped a byte");

    // Closed-port results carry no host activity
    a_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && avail_reg[8]) |-> (!rv_reg && !acc_reg))
        else $error("closed port reported host activity");

    // A handled item always yields a result next cycle
    a_fire_out: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid_reg)
        else $error("handled item produced no result");

    // A blocked input item is held
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !out_free) |=> (s1_valid_reg && $stable(s1_mode_reg)))
        else $error("blocked item lost");

endmodule

// File: rtl/core/uartrb_cfg.sv
module uartrb_cfg (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [uartrb_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [uartrb_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [uartrb_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                 pready,
    output uartrb_pkg::cfg_t                     cfg
);
    import uartrb_pkg::*;

    logic       port_open_reg, port_open_next;
    logic [3:0] rx_lg_reg, rx_lg_next;
    logic [3:0] tx_lg_reg, tx_lg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];

    // Decode register writes
    always_comb begin
        port_open_next = port_open_reg;
        rx_lg_next     = rx_lg_reg;
        tx_lg_next     = tx_lg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_PORT_OPEN: port_open_next = pwdata[0];
                REG_RX_SIZE:   rx_lg_next     = pwdata[3:0];
                REG_TX_SIZE:   tx_lg_next     = pwdata[3:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            port_open_reg <= 1'b0;
            rx_lg_reg     <= SIZE_LG_RESET;
            tx_lg_reg     <= SIZE_LG_RESET;
        end else begin
            port_open_reg <= port_open_next;
            rx_lg_reg     <= rx_lg_next;
            tx_lg_reg     <= tx_lg_next;
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            REG_PORT_OPEN: prdata = {{(APB_DATA_W-1){1'b0}}, port_open_reg};
            REG_RX_SIZE:   prdata = {{(APB_DATA_W-4){1'b0}}, rx_lg_reg};
            REG_TX_SIZE:   prdata = {{(APB_DATA_W-4){1'b0}}, tx_lg_reg};
            default:       prdata = '0;
        endcase
    end

    // A size write empties its ring
    always_comb begin
        cfg.port_open  = port_open_reg;
        cfg.rx_size_lg = rx_lg_reg;
        cfg.tx_size_lg = tx_lg_reg;
        cfg.rx_clear   = wr_en && (reg_idx == REG_RX_SIZE);
        cfg.tx_clear   = wr_en && (reg_idx == REG_TX_SIZE);
    end

endmodule

// File: rtl/core/uartrb_ring.sv
module uartrb_ring #(
    parameter int MAX_DEPTH = uartrb_pkg::MAX_DEPTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [3:0]                           size_lg,
    input  uartrb_pkg::ring_ctrl_t               ctrl,
    input  logic [7:0]                           wr_data,
    output uartrb_pkg::ring_stat_t               stat,
    output logic [$clog2(MAX_DEPTH+1)-2:0]       count,
    output logic [7:0]                           rd_data
);
    import uartrb_pkg::*;

    // Largest power of two not above MAX_DEPTH
    localparam int AW    = $clog2(MAX_DEPTH + 1) - 1;
    localparam int DEPTH = 1 << AW;

    logic [3:0]    eff_lg;
    logic [AW:0]   mask_full;
    logic [AW-1:0] mask;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [AW-1:0] head_inc, tail_inc;
    logic [7:0]    store_reg [DEPTH];
    logic [7:0]    rd_data_reg;

    // Clamp the size to 1..AW and form the index mask
    always_comb begin
        priority if (size_lg == 4'd0) begin
            eff_lg = 4'd1;
        end else if (size_lg > 4'(AW)) begin
            eff_lg = 4'(AW);
        end else begin
            eff_lg = size_lg;
        end
        mask_full = ((AW+1)'(1) << eff_lg) - (AW+1)'(1);
        mask      = mask_full[AW-1:0];
    end

    assign head_inc   = (head_reg + AW'(1)) & mask;
    assign tail_inc   = (tail_reg + AW'(1)) & mask;
    assign stat.empty = (head_reg == tail_reg);
    assign stat.full  = (head_inc == tail_reg);
    assign count      = (head_reg - tail_reg) & mask;
    assign rd_data    = rd_data_reg;

    // Advance pointers
    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        priority if (ctrl.clear) begin
            head_next = '0;
            tail_next = '0;
        end else if (ctrl.flush) begin
            head_next = tail_reg;
        end else begin
            if (ctrl.push) head_next = head_inc;
            if (ctrl.pop)  tail_next = tail_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    // Byte store: write at head, registered read at tail
    always_ff @(posedge aclk) begin
        if (ctrl.push) store_reg[head_reg] <= wr_data;
        if (ctrl.pop)  rd_data_reg <= store_reg[tail_reg];
    end

endmodule

// File: verif/uart_rx_tx_ring_buffers_tb.sv
module uart_rx_tx_ring_buffers_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import uartrb_pkg::*;

    // Mode codes the block treats as no operation
    localparam logic [2:0] MODE_NOP_LO = 3'd5;
    localparam logic [2:0] MODE_NOP_HI = 3'd7;
    // Register index past the end of the register list
    localparam logic [1:0] REG_SPARE = 2'd3;
    // Extra idle wait after the results are back, with margin
    localparam int SETTLE_CYCLES = 8;

    // Result fields, read_data in the lowest bits as on m_tdata
    typedef struct packed {
        logic       tx_request;
        logic [8:0] rx_available;
        logic       accepted;
        logic       line_valid;
        logic [7:0] line_data;
        logic       read_valid;
        logic [7:0] read_data;
    } ring_outcome_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    uart_rx_tx_ring_buffers i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Shadow copy of the rings and registers
    logic [7:0] rx_ring [256];
    logic [7:0] tx_ring [256];
    logic [7:0] rx_wr_ptr = '0;
    logic [7:0] rx_rd_ptr = '0;
    logic [7:0] tx_wr_ptr = '0;
    logic [7:0] tx_rd_ptr = '0;
    logic       tx_req = 1'b0;
    logic       open_shadow = 1'b0;
    logic [3:0] rx_lg_shadow = SIZE_LG_RESET;
    logic [3:0] tx_lg_shadow = SIZE_LG_RESET;

    ring_outcome_t outcomes_due [$];
    int  errors = 0;
    bit  quiet = 1'b0;
    int  rx_stall_left = 0;

    // Clock
    initial begin
        forever #10 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Slot mask for a size register value, clamped to 2..256 slots
    function automatic logic [7:0] slot_mask(logic [3:0] lg);
        logic [3:0] n;
        n = lg;
        if (n < 4'd1) n = 4'd1;
        if (n > 4'd8) n = 4'd8;
        return 8'((9'd1 << n) - 9'd1);
    endfunction

    // Apply one event to the shadow rings and return the result it gives
    function automatic ring_outcome_t apply_ring_event(logic [2:0] mode, logic [7:0] byte_in);
        ring_outcome_t o;
        logic [7:0] rm;
        logic [7:0] tm;
        logic [7:0] nxt;
        o = '0;
        rm = slot_mask(rx_lg_shadow);
        tm = slot_mask(tx_lg_shadow);
        case (mode)
            MODE_HOST_WR: begin
                if (open_shadow) begin
                    nxt = (tx_wr_ptr + 8'd1) & tm;
                    if (nxt != (tx_rd_ptr & tm)) begin
                        tx_ring[tx_wr_ptr & tm] = byte_in;
                        tx_wr_ptr = nxt;
                        o.accepted = 1'b1;
                    end
                    tx_req = 1'b1;
                end
            end
            MODE_HOST_RD: begin
                if (open_shadow && ((rx_wr_ptr ^ rx_rd_ptr) & rm) != 8'd0) begin
                    o.read_data = rx_ring[rx_rd_ptr & rm];
                    o.read_valid = 1'b1;
                    rx_rd_ptr = (rx_rd_ptr + 8'd1) & rm;
                end
            end
            MODE_LINE_RX: begin
                if (open_shadow) begin
                    nxt = (rx_wr_ptr + 8'd1) & rm;
                    if (nxt != (rx_rd_ptr & rm)) begin
                        rx_ring[rx_wr_ptr & rm] = byte_in;
                        rx_wr_ptr = nxt;
                        o.accepted = 1'b1;
                    end
                end
            end
            MODE_TX_RDY: begin
                if (((tx_wr_ptr ^ tx_rd_ptr) & tm) != 8'd0) begin
                    o.line_data = tx_ring[tx_rd_ptr & tm];
                    o.line_valid = 1'b1;
                    tx_rd_ptr = (tx_rd_ptr + 8'd1) & tm;
                end else begin
                    tx_req = 1'b0;
                end
            end
            MODE_FLUSH: begin
                rx_wr_ptr = rx_rd_ptr;
                tx_rd_ptr = tx_wr_ptr;
            end
            default: begin
            end
        endcase
        if (open_shadow)
            o.rx_available = {1'b0, (rx_wr_ptr - rx_rd_ptr) & rm};
        else
            o.rx_available = 9'h1FF;
        o.tx_request = tx_req;
        return o;
    endfunction

    // Predict on every accepted item, check every accepted result
    always @(posedge aclk) begin
        ring_outcome_t want;
        logic [M_TDATA_W-1:0] want_word;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                outcomes_due.push_back(apply_ring_event(s_tdata[2:0], s_tdata[10:3]));
            if (m_tvalid && m_tready) begin
                if (outcomes_due.size() == 0) begin
                    $display("%0t: unexpected result item %h", $time, m_tdata);
                    errors++;
                end else begin
                    want = outcomes_due.pop_front();
                    want_word = {3'b000, want};
                    if (m_tdata !== want_word) begin
                        $display("%0t: result mismatch: expected %h, actual %h", $time,
                                 want_word, m_tdata);
                        $display("    rd %h/%h rv %b/%b ld %h/%h lv %b/%b acc %b/%b",
                                 want.read_data, m_tdata[7:0], want.read_valid, m_tdata[8],
                                 want.line_data, m_tdata[16:9], want.line_valid, m_tdata[17],
                                 want.accepted, m_tdata[18]);
                        $display("    avail %h/%h txreq %b/%b",
                                 want.rx_available, m_tdata[27:19], want.tx_request,
                                 m_tdata[28]);
                        errors++;
                    end
                end
            end
        end
    end

    // Result side: stall in random bursts unless quiet
    always @(posedge aclk) begin
        if (rx_stall_left > 0) begin
            rx_stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 9) == 0)
                rx_stall_left = $urandom_range(1, 17);
        end
    end

    // Send one item, with an occasional idle burst ahead of it
    task automatic send_item(logic [2:0] mode, logic [7:0] byte_in);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'b00000, byte_in, mode};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop valid and wait until every result is back and the pipe is empty
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outcomes_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register write over the configuration port; block must be idle
    task automatic reg_write(logic [1:0] idx, logic [APB_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_PORT_OPEN: open_shadow = value[0];
            REG_RX_SIZE: begin
                rx_lg_shadow = value[3:0];
                rx_wr_ptr = '0;
                rx_rd_ptr = '0;
            end
            REG_TX_SIZE: begin
                tx_lg_shadow = value[3:0];
                tx_wr_ptr = '0;
                tx_rd_ptr = '0;
            end
            default: begin
            end
        endcase
        @(posedge aclk);
    endtask

    // Weighted mode pick with a little noise from unused codes
    function automatic logic [2:0] pick_mode(int w_wr, int w_rd, int w_rx, int w_tx, int w_fl);
        int r;
        if ($urandom_range(0, 99) < 3)
            return 3'($urandom_range(MODE_NOP_LO, MODE_NOP_HI));
        r = $urandom_range(0, w_wr + w_rd + w_rx + w_tx + w_fl - 1);
        if (r < w_wr) return MODE_HOST_WR;
        r -= w_wr;
        if (r < w_rd) return MODE_HOST_RD;
        r -= w_rd;
        if (r < w_rx) return MODE_LINE_RX;
        r -= w_rx;
        if (r < w_tx) return MODE_TX_RDY;
        return MODE_FLUSH;
    endfunction

    task automatic run_random(int count, int w_wr, int w_rd, int w_rx, int w_tx, int w_fl);
        for (int k = 0; k < count; k++)
            send_item(pick_mode(w_wr, w_rd, w_rx, w_tx, w_fl), 8'($urandom));
        drain();
    endtask

    // Port closed after reset: host items and line bytes ignored, transmit ready and flush still act
    task automatic test_closed_after_reset();
        send_item(MODE_HOST_WR, 8'hFF);
        send_item(MODE_HOST_RD, 8'h00);
        send_item(MODE_LINE_RX, 8'hFF);
        send_item(MODE_TX_RDY, 8'h00);
        send_item(MODE_FLUSH, 8'h00);
        send_item(MODE_NOP_HI, 8'hFF);
        drain();
    endtask

    // Two-slot rings: full, empty, request set and cleared, flush
    task automatic test_two_slot_rings();
        reg_write(REG_PORT_OPEN, 32'd1);
        reg_write(REG_RX_SIZE, 32'd1);
        reg_write(REG_TX_SIZE, 32'd1);
        send_item(MODE_HOST_WR, 8'h00);
        send_item(MODE_HOST_WR, 8'hFF);
        send_item(MODE_LINE_RX, 8'hFF);
        send_item(MODE_LINE_RX, 8'h00);
        send_item(MODE_HOST_RD, 8'h00);
        send_item(MODE_HOST_RD, 8'h00);
        send_item(MODE_TX_RDY, 8'h00);
        send_item(MODE_TX_RDY, 8'h00);
        send_item(MODE_TX_RDY, 8'h00);
        send_item(MODE_HOST_WR, 8'hA5);
        send_item(MODE_LINE_RX, 8'h5A);
        send_item(MODE_FLUSH, 8'h00);
        send_item(MODE_HOST_RD, 8'h00);
        send_item(MODE_TX_RDY, 8'h00);
        send_item(MODE_NOP_LO, 8'h00);
        drain();
    endtask

    // Size clamping, size write empties a ring, spare index, closing with data held
    task automatic test_size_limits();
        reg_write(REG_RX_SIZE, 32'd0);
        reg_write(REG_TX_SIZE, 32'd15);
        reg_write(REG_SPARE, 32'd0);
        send_item(MODE_LINE_RX, 8'h01);
        send_item(MODE_LINE_RX, 8'h80);
        send_item(MODE_HOST_WR, 8'h7F);
        send_item(MODE_HOST_WR, 8'hFE);
        drain();
        reg_write(REG_TX_SIZE, 32'd9);
        send_item(MODE_TX_RDY, 8'h00);
        send_item(MODE_HOST_WR, 8'h3C);
        drain();
        reg_write(REG_PORT_OPEN, 32'd0);
        send_item(MODE_HOST_RD, 8'h00);
        send_item(MODE_HOST_WR, 8'hC3);
        send_item(MODE_TX_RDY, 8'h00);
        send_item(MODE_FLUSH, 8'h00);
        drain();
        reg_write(REG_PORT_OPEN, 32'd1);
        send_item(MODE_HOST_RD, 8'h00);
        drain();
    endtask

    // Small rings, balanced then skewed traffic so both rings wrap and fill often
    task automatic test_small_rings_random();
        reg_write(REG_RX_SIZE, 32'd1);
        reg_write(REG_TX_SIZE, 32'd2);
        run_random(40, 20, 20, 20, 20, 3);
        reg_write(REG_RX_SIZE, 32'd3);
        reg_write(REG_TX_SIZE, 32'd3);
        run_random(20, 30, 10, 30, 10, 2);
        run_random(20, 10, 30, 10, 30, 2);
    endtask

    // Largest rings, write-heavy until the transmit ring fills
    task automatic test_deep_rings_random();
        reg_write(REG_RX_SIZE, 32'd8);
        reg_write(REG_TX_SIZE, 32'd8);
        run_random(300, 92, 1, 4, 3, 0);
        run_random(40, 5, 30, 30, 30, 5);
    endtask

    // Closed port under random traffic, register values with stray upper bits
    task automatic test_closed_random();
        reg_write(REG_RX_SIZE, {$urandom} & 32'hFFFF_FFF0 | 32'd5);
        reg_write(REG_TX_SIZE, {$urandom} & 32'hFFFF_FFF0 | 32'd4);
        reg_write(REG_PORT_OPEN, {$urandom} & 32'hFFFF_FFFE);
        run_random(30, 25, 25, 25, 20, 5);
        reg_write(REG_PORT_OPEN, {$urandom} | 32'd1);
    endtask

    // Final stretch at full rate on both sides
    task automatic test_full_rate();
        quiet = 1'b1;
        rx_stall_left = 0;
        reg_write(REG_RX_SIZE, 32'd2);
        reg_write(REG_TX_SIZE, 32'd1);
        run_random(40, 25, 20, 25, 25, 5);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_closed_after_reset();
        test_two_slot_rings();
        test_size_limits();
        test_small_rings_random();
        test_deep_rings_random();
        test_closed_random();
        test_full_rate();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0 && outcomes_due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/uartrb_pkg.sv
rtl/core/uartrb_cfg.sv
rtl/core/uartrb_ring.sv
rtl/core/uart_rx_tx_ring_buffers.sv
verif/uart_rx_tx_ring_buffers_tb.sv
